@@ design/text_line_number_filter_macros.svh @@
// Assertion macros shared by the checker of the line number filter.
`ifndef TEXT_LINE_NUMBER_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLNF_CHECK_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("text_line_number_filter: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLNF_CHECK_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("text_line_number_filter: check failed");

`endif

@@ design/tlnf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlnf_pkg
// Types and constants shared by the line number filter modules.
// ----------------------------------------------------------------------------
package tlnf_pkg;

	localparam int DigitCap = 6;
	localparam int StepW    = 4;

	localparam logic [7:0] ByteNl     = 8'h0A;
	localparam logic [7:0] ByteTab    = 8'h09;
	localparam logic [7:0] ByteCaret  = 8'h5E;
	localparam logic [7:0] ByteDollar = 8'h24;
	localparam logic [7:0] ByteSpace  = 8'h20;
	localparam logic [7:0] ByteZero   = 8'h30;
	localparam logic [7:0] CtlOffset  = 8'h40;
	localparam logic [7:0] CtlMax     = 8'd31;

	localparam logic [2:0] RegNumberNonblank = 3'd0;
	localparam logic [2:0] RegNumberAll      = 3'd1;
	localparam logic [2:0] RegShowEnds      = 3'd2;
	localparam logic [2:0] RegSqueeze        = 3'd3;
	localparam logic [2:0] RegShowTabs       = 3'd4;
	localparam logic [2:0] RegShowCtl        = 3'd5;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_of_file;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_word_t;

	typedef struct packed {
		logic number_nonblank;
		logic number_all_lines;
		logic show_line_ends;
		logic squeeze_blank_lines;
		logic show_tab_marks;
		logic show_control_bytes;
	} cfg_t;

	// One classified input byte, waiting to be expanded into output words.
	typedef struct packed {
		logic                         numbered;
		logic [DigitCap-1:0][3:0]     digits;
		logic                         mark_valid;
		logic                         mark_caret;
		logic [7:0]                   final_byte;
	} job_t;

endpackage

@@ design/tlnf_front.sv @@
// ----------------------------------------------------------------------------
// tlnf_front
// Accepts input bytes, tracks line state and the decimal line count, and
// classifies each byte into a job for the back end.
// ----------------------------------------------------------------------------
module tlnf_front import tlnf_pkg::*; #(
	parameter int NumW = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  in_word_t item,
	input  logic     accept,
	output logic     wr_en,
	output job_t     job
);

	logic                 prev_nl_q;
	logic                 blank_q;
	logic [NumW-1:0][3:0] cnt_q;

	logic                 prev_nl;
	logic                 blank;
	logic [NumW-1:0][3:0] cnt;
	logic [NumW-1:0][3:0] cnt_next;
	logic                 is_nl;
	logic                 is_tab;
	logic                 is_ctl;
	logic                 squeezed;
	logic                 numbered;
	logic                 all_nine;
	logic                 carry;

	always_comb begin
		prev_nl = item.first_of_file ? 1'b1 : prev_nl_q;
		blank   = item.first_of_file ? 1'b0 : blank_q;
		cnt     = item.first_of_file ? '0 : cnt_q;

		is_nl  = (item.text_byte == ByteNl);
		is_tab = (item.text_byte == ByteTab);
		is_ctl = (item.text_byte <= CtlMax) && !is_nl && !is_tab;

		squeezed = cfg.squeeze_blank_lines && prev_nl && is_nl && blank;
		numbered = prev_nl && ((cfg.number_nonblank && !is_nl) ||
			(!cfg.number_nonblank && cfg.number_all_lines));

		// The count is kept in decimal digits and sticks at all nines.
		all_nine = 1'b1;
		for (int i = 0; i < NumW; i++) begin
			all_nine = all_nine && (cnt[i] == 4'd9);
		end
		carry    = numbered && !all_nine;
		cnt_next = cnt;
		for (int i = 0; i < NumW; i++) begin
			if (carry) begin
				if (cnt[i] == 4'd9) begin
					cnt_next[i] = 4'd0;
				end else begin
					cnt_next[i] = cnt[i] + 4'd1;
					carry       = 1'b0;
				end
			end
		end

		job            = '0;
		job.numbered   = numbered;
		job.digits[NumW-1:0] = cnt_next;
		job.mark_valid = (cfg.show_line_ends && is_nl) ||
			(cfg.show_tab_marks && is_tab) || (cfg.show_control_bytes && is_ctl);
		job.mark_caret = !is_nl;
		if (cfg.show_tab_marks && is_tab) begin
			job.final_byte = ByteTab | CtlOffset;
		end else if (cfg.show_control_bytes && is_ctl) begin
			job.final_byte = item.text_byte | CtlOffset;
		end else begin
			job.final_byte = item.text_byte;
		end

		wr_en = accept && !squeezed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_nl_q <= 1'b1;
			blank_q   <= 1'b0;
			cnt_q     <= '0;
		end else if (accept && !squeezed) begin
			prev_nl_q <= is_nl;
			blank_q   <= prev_nl && is_nl;
			cnt_q     <= cnt_next;
		end
	end

endmodule

@@ design/tlnf_queue.sv @@
// ----------------------------------------------------------------------------
// tlnf_queue
// Short queue of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
module tlnf_queue import tlnf_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic rd_valid,
	output logic full
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign rd_valid = (count_q != '0);
	assign full     = (count_q == CntW'(Depth));
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/tlnf_back.sv @@
// ----------------------------------------------------------------------------
// tlnf_back
// Expands the job at the head of the queue into output words through a
// registered output stage, one per cycle while the receiver does not stall it.
// ----------------------------------------------------------------------------
module tlnf_back import tlnf_pkg::*; #(
	parameter int NumW = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_done,
	input  logic      pop,
	output logic      empty,
	output out_word_t result
);

	logic [StepW-1:0] step_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic [NumW-1:0]  lead_zero;
	logic [7:0]       digit_char;
	logic [7:0]       cur_byte;
	logic [StepW-1:0] mark_step;
	logic [StepW-1:0] n_bytes;
	logic             is_last;
	logic             advance;

	always_comb begin
		// A digit shows as a space while it and every higher digit are zero,
		// except the lowest one.
		lead_zero[NumW-1] = (job.digits[NumW-1] == 4'd0);
		for (int j = NumW - 2; j >= 0; j--) begin
			lead_zero[j] = lead_zero[j+1] && (job.digits[j] == 4'd0);
		end
		digit_char = ByteSpace;
		for (int i = 0; i < NumW; i++) begin
			if (step_q == StepW'(i)) begin
				if (i < NumW - 1 && lead_zero[NumW-1-i]) begin
					digit_char = ByteSpace;
				end else begin
					digit_char = ByteZero | {4'd0, job.digits[NumW-1-i]};
				end
			end
		end

		mark_step = job.numbered ? StepW'(NumW + 1) : '0;
		n_bytes   = mark_step + StepW'(job.mark_valid) + StepW'(1);
		is_last   = (step_q == n_bytes - StepW'(1));

		if (job.numbered && step_q < StepW'(NumW)) begin
			cur_byte = digit_char;
		end else if (job.numbered && step_q == StepW'(NumW)) begin
			cur_byte = ByteTab;
		end else if (job.mark_valid && step_q == mark_step) begin
			cur_byte = job.mark_caret ? ByteCaret : ByteDollar;
		end else begin
			cur_byte = job.final_byte;
		end

		advance  = job_valid && (!out_valid_q || pop);
		job_done = advance && is_last;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte    <= cur_byte;
			out_q.last_of_run <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? '0 : step_q + StepW'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ design/text_line_number_filter.sv @@
// ----------------------------------------------------------------------------
// text_line_number_filter
// Line numbering text filter: one text byte in, zero to nine bytes out.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: a word (text byte plus first of file
// mark) is taken at a clock edge with push high and full low. The output side
// is a queue read port: while empty is low the oldest output word is on
// result, and pop high at a clock edge takes it. last_of_run marks the last
// word produced by one input byte. A squeezed blank line produces no word.
// Mode bits are written through cfg_en, cfg_index and cfg_data; the user must
// write them only while idle, which the block does not enforce. An accepted
// word passes the job queue, then the output register. While the receiver pops
// every cycle the back end sends one output word per cycle, and a byte of n
// words (1 to 9) holds it until its last word is sent; the front takes one
// byte per cycle while the two-entry job queue has room, so single-word bytes
// stream at one per cycle. Reset clears the mode bits, line state, job queue
// and output register. When the receiver stops popping, the output register
// holds its word, the job queue fills, and full rises to stall the sender.
// ----------------------------------------------------------------------------
module text_line_number_filter import tlnf_pkg::*; #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  item,
	output logic      empty,
	input  logic      pop,
	output out_word_t result,
	input  logic      cfg_en,
	input  logic [2:0] cfg_index,
	input  logic      cfg_data
);

	localparam int NumW = (NUMBER_DIGITS < 1) ? 1 :
		((NUMBER_DIGITS > DigitCap) ? DigitCap : NUMBER_DIGITS);

	cfg_t cfg_q;
	logic wr_en;
	job_t wr_job;
	job_t rd_job;
	logic rd_valid;
	logic job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				RegNumberNonblank: cfg_q.number_nonblank     <= cfg_data;
				RegNumberAll:      cfg_q.number_all_lines    <= cfg_data;
				RegShowEnds:       cfg_q.show_line_ends      <= cfg_data;
				RegSqueeze:        cfg_q.squeeze_blank_lines <= cfg_data;
				RegShowTabs:       cfg_q.show_tab_marks      <= cfg_data;
				RegShowCtl:        cfg_q.show_control_bytes  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tlnf_front #(.NumW(NumW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.accept (push && !full),
		.wr_en  (wr_en),
		.job    (wr_job)
	);

	tlnf_queue #(.Depth(2)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_job),
		.rd_en    (job_done),
		.rd_data  (rd_job),
		.rd_valid (rd_valid),
		.full     (full)
	);

	tlnf_back #(.NumW(NumW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.job_valid (rd_valid),
		.job_done  (job_done),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

@@ design/tlnf_checker.sv @@
// ----------------------------------------------------------------------------
// tlnf_checker
// Port level checks for the line number filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_line_number_filter_macros.svh"

module tlnf_checker import tlnf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_word_t result
);

	// A waiting word does not change until it is taken.
	`TLNF_CHECK_NOW(a_hold_result, !empty && $past(!empty && !pop), $stable(result))

	// The words of one input byte come out without a gap.
	`TLNF_CHECK_NEXT(a_run_contiguous, !empty && pop && !result.last_of_run, !empty)

	// The job queue can only fill through an accepted word.
	`TLNF_CHECK_NEXT(a_full_needs_push, !full && !push, !full)

	// With no word taken and nothing shown, and so no job left in the queue, nothing appears.
	`TLNF_CHECK_NEXT(a_no_invented_word,
		(empty && !(push && !full)) ##1 (empty && !(push && !full)), empty)

endmodule

bind text_line_number_filter tlnf_checker u_checker (.*);

@@ dv/tb_text_line_number_filter.sv @@
// ----------------------------------------------------------------------------
// tb_text_line_number_filter
// Self-checking bench for the line number filter. Text bytes go in through
// the push side and each one is expanded by a model of the filter into the
// output words it should cause. Every popped word is checked against the
// oldest one still owed. Directed tests cover plain pass through, numbering,
// squeezing and caret marks. Random text then runs under several mode
// settings. Both sides stall in random bursts, except in the last phase.
// Counter saturation needs about a million numbered lines, so it is not
// reached here.
// ----------------------------------------------------------------------------
module tb_text_line_number_filter;
	import tlnf_pkg::*;

	localparam int NumDigits   = 6;
	localparam int DigitW      = (NumDigits < 1) ? 1 : (NumDigits > DigitCap) ? DigitCap :
		NumDigits;
	localparam int CountLimit  = (10 ** DigitW - 1 > 20'hFFFFF) ? 20'hFFFFF : 10 ** DigitW - 1;
	localparam int SettleCycles = 6;
	localparam int CycleLimit  = 400000;
	localparam int PhaseItems  = 41;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	in_word_t   item;
	logic       empty;
	logic       pop;
	out_word_t  result;
	logic       cfg_en;
	logic [2:0] cfg_index;
	logic       cfg_data;

	// Filter state as the model sees it.
	cfg_t        mode;
	logic [7:0]  prev_byte;
	logic [19:0] line_num;
	logic        blank_seen;

	out_word_t   owed_words[$];
	out_word_t   want;
	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	logic        calm = 1'b0;

	text_line_number_filter #(.NUMBER_DIGITS(NumDigits)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Expands one accepted text byte into the words it should produce.
	task automatic expand_byte(in_word_t w);
		logic [7:0] c;
		logic [7:0] words[$];
		logic [7:0] num_text[DigitW];
		logic [19:0] v;
		logic prev_nl;
		c = w.text_byte;
		if (w.first_of_file) begin
			prev_byte  = ByteNl;
			line_num   = '0;
			blank_seen = 1'b0;
		end
		prev_nl = (prev_byte == ByteNl);
		if (mode.squeeze_blank_lines && prev_nl && c == ByteNl && blank_seen)
			return;
		blank_seen = prev_nl && c == ByteNl;
		if (prev_nl && ((mode.number_nonblank && c != ByteNl) ||
				(!mode.number_nonblank && mode.number_all_lines))) begin
			if (line_num < CountLimit)
				line_num = line_num + 1'b1;
			v = line_num;
			for (int i = DigitW - 1; i >= 0; i--) begin
				if (i == DigitW - 1 || v != 0) begin
					num_text[i] = ByteZero + 8'(v % 10);
					v = 20'(v / 10);
				end else begin
					num_text[i] = ByteSpace;
				end
			end
			for (int i = 0; i < DigitW; i++)
				words.push_back(num_text[i]);
			words.push_back(ByteTab);
		end
		if (mode.show_line_ends && c == ByteNl)
			words.push_back(ByteDollar);
		if (mode.show_tab_marks && c == ByteTab) begin
			words.push_back(ByteCaret);
			c = ByteTab + CtlOffset;
		end
		if (mode.show_control_bytes && c <= CtlMax && c != ByteNl && c != ByteTab) begin
			words.push_back(ByteCaret);
			c = c + CtlOffset;
		end
		words.push_back(c);
		prev_byte = c;
		foreach (words[k])
			owed_words.push_back({words[k], logic'(k == words.size() - 1)});
	endtask

	// Both handshakes and the mode writes are sampled here, once per edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_en) begin
				case (cfg_index)
					RegNumberNonblank: mode.number_nonblank     = cfg_data;
					RegNumberAll:      mode.number_all_lines    = cfg_data;
					RegShowEnds:       mode.show_line_ends      = cfg_data;
					RegSqueeze:        mode.squeeze_blank_lines = cfg_data;
					RegShowTabs:       mode.show_tab_marks      = cfg_data;
					RegShowCtl:        mode.show_control_bytes  = cfg_data;
					default: ;
				endcase
			end
			if (push && !full)
				expand_byte(item);
			if (pop && !empty) begin
				if (owed_words.size() == 0) begin
					$error("unexpected word: out_byte %h, last_of_run %b",
						result.out_byte, result.last_of_run);
					failures++;
				end else begin
					want = owed_words.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
						failures++;
					end
					if (result.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b",
							want.last_of_run, result.last_of_run);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: stretches of pops and stall bursts are drawn at random, no stalls when calm.
	initial begin : pop_driver
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Push stays high from one word to the next unless a gap is drawn.
	task automatic send_byte(logic [7:0] b, logic fresh);
		if (!calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item <= {b, fresh};
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(string s, logic fresh);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fresh && i == 0);
	endtask

	// A squeezed line leaves nothing owed while the filter may still be busy,
	// so the task keeps waiting after the last owed word. Push drops first, and
	// the owed list is checked only once the last accepted word is in it.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes all six mode bits back to back, then the unused indexes, which
	// must be ignored.
	task automatic apply_modes(cfg_t m);
		logic bits[8];
		bits[RegNumberNonblank] = m.number_nonblank;
		bits[RegNumberAll]      = m.number_all_lines;
		bits[RegShowEnds]       = m.show_line_ends;
		bits[RegSqueeze]        = m.squeeze_blank_lines;
		bits[RegShowTabs]       = m.show_tab_marks;
		bits[RegShowCtl]        = m.show_control_bytes;
		for (int i = RegShowCtl + 1; i < 8; i++)
			bits[i] = 1'($urandom_range(0, 1));
		cfg_en <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= 3'(i);
			cfg_data  <= bits[i];
			@(posedge clk);
		end
		cfg_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return ByteNl;
			3:       return ByteTab;
			4:       return 8'($urandom_range(0, 31));
			5:       return 8'($urandom_range(127, 255));
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// Modes at reset: every byte passes through as it is.
	task automatic test_plain_passthrough();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(ByteTab, 1'b0);
		send_byte(CtlMax, 1'b0);
		send_text("\n\n", 1'b0);
		wait_idle();
	endtask

	task automatic test_line_numbers();
		cfg_t m;
		m = '0;
		m.number_all_lines = 1'b1;
		m.show_line_ends   = 1'b1;
		apply_modes(m);
		send_text("ab\n\n", 1'b1);
		wait_idle();
	endtask

	// Nonblank numbering wins over numbering all lines; runs of empty lines
	// shrink to one, and a new file restarts the count.
	task automatic test_nonblank_squeeze();
		cfg_t m;
		m = '0;
		m.number_nonblank     = 1'b1;
		m.number_all_lines    = 1'b1;
		m.show_line_ends      = 1'b1;
		m.squeeze_blank_lines = 1'b1;
		apply_modes(m);
		send_text("\n\n\nx\n\n\n", 1'b1);
		send_byte("y", 1'b1);
		wait_idle();
	endtask

	task automatic test_caret_marks();
		cfg_t m;
		m = '0;
		m.show_tab_marks     = 1'b1;
		m.show_control_bytes = 1'b1;
		apply_modes(m);
		send_byte(8'h00, 1'b1);
		send_byte(ByteTab, 1'b0);
		send_byte(CtlMax, 1'b0);
		send_byte(ByteNl, 1'b0);
		send_byte(8'h80, 1'b0);
		wait_idle();
		// Without tab marks a tab is not a control byte and goes out plain.
		m.show_tab_marks = 1'b0;
		apply_modes(m);
		send_byte(ByteTab, 1'b0);
		send_byte(8'h1B, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_text();
		cfg_t m;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       m = '0;
				1:       m = '1;
				default: m = cfg_t'($urandom_range(0, 63));
			endcase
			calm = (phase == 4);
			apply_modes(m);
			for (int i = 0; i < PhaseItems; i++)
				send_byte(pick_text_byte(), logic'($urandom_range(0, 24) == 0));
			wait_idle();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_en    = 1'b0;
		cfg_index = '0;
		cfg_data  = 1'b0;
		mode       = '0;
		prev_byte  = ByteNl;
		line_num   = '0;
		blank_seen = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_passthrough();
		test_line_numbers();
		test_nonblank_squeeze();
		test_caret_marks();
		test_random_text();
		wait_idle();
		if (failures == 0 && owed_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ text_line_number_filter.f @@
+incdir+design
design/tlnf_pkg.sv
design/tlnf_front.sv
design/tlnf_queue.sv
design/tlnf_back.sv
design/text_line_number_filter.sv
design/tlnf_checker.sv
dv/tb_text_line_number_filter.sv
